>>> hdl/lkvc_pkg.sv
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;
  localparam int unsigned CAP_RST_DEF = 16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

  typedef struct packed {
    logic                    operation;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
  } out_word_t;

  // update command broadcast to every cell
  typedef struct packed {
    logic                    op_set;
    logic                    found;
    logic                    insert;
    logic                    evict;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  // lookup results handed from cell to cell
  typedef struct packed {
    logic                    hit;
    logic                    free;
    logic signed [VAL_W-1:0] value;
  } chain_t;

endpackage

>>> hdl/lkvc_cell.sv
`timescale 1ns / 1ps

module lkvc_cell #(
  parameter int unsigned RW = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             upd,
  input  lkvc_pkg::cmd_t   cmd,
  input  logic [RW-1:0]    oldest_age,
  input  logic [RW-1:0]    found_age,
  input  lkvc_pkg::chain_t chain_in,
  input  logic [RW-1:0]    age_in,
  output lkvc_pkg::chain_t chain_out,
  output logic [RW-1:0]    age_out,
  output logic             valid
);
  import lkvc_pkg::*;

  logic                    valid_r;
  logic [RW-1:0]           rec_r;
  logic signed [KEY_W-1:0] key_r;
  logic signed [VAL_W-1:0] val_r;

  logic match;
  logic first_free;
  logic is_oldest;
  logic target;

  assign match      = valid_r && (key_r == cmd.key);
  assign first_free = !valid_r && !chain_in.free;
  assign is_oldest  = valid_r && (rec_r == oldest_age);
  assign target     = cmd.insert && (cmd.evict ? is_oldest : first_free);

  assign chain_out.hit   = chain_in.hit | match;
  assign chain_out.free  = chain_in.free | !valid_r;
  assign chain_out.value = chain_in.value | (match ? val_r : '0);
  assign age_out         = age_in | (match ? rec_r : '0);
  assign valid           = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r <= 1'b0;
      rec_r   <= '0;
    end else if (upd) begin
      if (cmd.found) begin
        if (match) begin
          rec_r <= '0;
        end else if (valid_r && rec_r < found_age) begin
          rec_r <= rec_r + 1'b1;
        end
      end else if (target) begin
        valid_r <= 1'b1;
        rec_r   <= '0;
      end else if (cmd.insert && valid_r) begin
        rec_r <= rec_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      if (cmd.found && match && cmd.op_set) begin
        val_r <= cmd.value;
      end else if (!cmd.found && target) begin
        key_r <= cmd.key;
        val_r <= cmd.value;
      end
    end
  end

endmodule

>>> hdl/lru_key_value_cache_unit.sv
`timescale 1ns / 1ps

// Fully associative key-value cache with least-recently-used replacement, built as a row of
// MAX_ENTRIES cells that each hold one key, value, valid bit and age. An operation is issued
// by raising start while busy is low; busy is then high for one cycle while every cell compares
// the key and applies the recency update, and the result word appears on out_data with out_valid
// high for exactly one cycle after that. A new operation may start in the cycle the result is
// shown. The result cannot be held off, so the receiver must take it in that cycle. A get that
// misses and every set return read_value of -1 with hit low. Writing the capacity register
// (byte address 0) empties the cache at once; do so only while no operation is in flight.

module lru_key_value_cache_unit #(
  parameter int unsigned MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lkvc_pkg::in_word_t  in_data,
  output logic                out_valid,
  output lkvc_pkg::out_word_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import lkvc_pkg::*;

  localparam int unsigned RW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW     = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMPW   = (CW > CAP_W) ? CW : CAP_W;
  localparam int unsigned CAPMAX = (MAX_ENTRIES < 31) ? MAX_ENTRIES : 31;
  localparam int unsigned CAPRST = (MAX_ENTRIES < CAP_RST_DEF) ? MAX_ENTRIES : CAP_RST_DEF;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  localparam logic REG_CAPACITY = 1'b0;

  logic              state_r, state_nxt;
  logic              op_r;
  logic signed [KEY_W-1:0] key_r;
  logic signed [VAL_W-1:0] val_r;
  logic [CAP_W-1:0]  capacity_r, capacity_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              out_valid_r;
  out_word_t         out_data_r;

  logic              accept;
  logic              cfg_wr;
  logic [CAP_W-1:0]  cap_raw;
  cmd_t              cmd;
  logic [RW-1:0]     oldest_age;
  logic              full;

  chain_t            chain [0:MAX_ENTRIES];
  logic [RW-1:0]     age_c [0:MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_vec;

  assign busy   = (state_r == ST_UPD);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, capacity_r} : '0;
  assign cap_raw = pwdata[CAP_W-1:0];

  always_comb begin
    capacity_nxt = capacity_r;
    if (cfg_wr) begin
      priority if (cap_raw == '0) begin
        capacity_nxt = CAP_W'(1);
      end else if (cap_raw > CAP_W'(CAPMAX)) begin
        capacity_nxt = CAP_W'(CAPMAX);
      end else begin
        capacity_nxt = cap_raw;
      end
    end
  end

  assign full       = CMPW'(count_r) >= CMPW'(capacity_r);
  assign oldest_age = RW'(count_r - 1'b1);

  assign cmd.op_set = (op_r == OP_SET);
  assign cmd.found  = chain[MAX_ENTRIES].hit;
  assign cmd.insert = (op_r == OP_SET) && !chain[MAX_ENTRIES].hit;
  assign cmd.evict  = cmd.insert && full;
  assign cmd.key    = key_r;
  assign cmd.value  = val_r;

  assign chain[0] = '0;
  assign age_c[0] = '0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    lkvc_cell #(
      .RW(RW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clear     (cfg_wr),
      .upd       (busy),
      .cmd       (cmd),
      .oldest_age(oldest_age),
      .found_age (age_c[MAX_ENTRIES]),
      .chain_in  (chain[g]),
      .age_in    (age_c[g]),
      .chain_out (chain[g+1]),
      .age_out   (age_c[g+1]),
      .valid     (valid_vec[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cfg_wr) begin
      count_nxt = '0;
    end else if (busy && cmd.insert && !cmd.evict) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      capacity_r  <= CAP_W'(CAPRST);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      capacity_r  <= capacity_nxt;
      count_r     <= count_nxt;
      out_valid_r <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_data.operation;
      key_r <= in_data.lookup_key;
      val_r <= in_data.write_value;
    end
    if (busy) begin
      out_data_r.hit        <= (op_r == OP_GET) && chain[MAX_ENTRIES].hit;
      out_data_r.read_value <= ((op_r == OP_GET) && chain[MAX_ENTRIES].hit)
                               ? chain[MAX_ENTRIES].value : MISS_VALUE;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after start");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy)
    else $error("result word missing after update");

  a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(count_r) <= CMPW'(capacity_r))
    else $error("entry count above capacity");

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("entry count disagrees with valid cells");

  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && out_valid && out_data.hit |-> $past(op_r) == OP_GET)
    else $error("hit flagged on a set");

endmodule
